[src/kcl_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants
// Request codes, register indexes, reset values and the control bundle that
// the core sends to each key machine.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned REG_W = 8;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [1:0] CFG_SAMPLE_DIVIDER = 2'd0;
  localparam logic [1:0] CFG_LONG_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_CLICK_DELAY    = 2'd2;

  localparam logic [REG_W-1:0] RST_SAMPLE_DIVIDER = 8'd20;
  localparam logic [REG_W-1:0] RST_LONG_LIMIT     = 8'd50;
  localparam logic [REG_W-1:0] RST_CLICK_DELAY    = 8'd1;

  // event bits
  localparam logic [1:0] EV_LONG  = 2'b01;
  localparam logic [1:0] EV_CLICK = 2'b10;
  localparam logic [1:0] EV_ALL   = 2'b11;

  typedef struct packed {
    logic       sample;    // take a pin sample this cycle
    logic       pin;       // pin level for the sample
    logic [1:0] clr_mask;  // event bits to drop
  } kcl_key_ctrl_t;

endpackage
`default_nettype wire

[src/kcl_key_fsm.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kcl_key_fsm: one key machine
// Edge detection on sampled levels, hold / release-wait counting and the
// latched long-press and click event bits of a single key.
// ----------------------------------------------------------------------------
module kcl_key_fsm (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire kcl_pkg::kcl_key_ctrl_t         ctrl,
  input  wire logic [kcl_pkg::REG_W-1:0]      long_limit,
  input  wire logic [kcl_pkg::REG_W-1:0]      click_delay,
  output logic      [1:0]                     pending
);
  import kcl_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_HOLD    = 2'd1,
    MODE_RELEASE = 2'd2
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic             prev_r, curr_r;
  logic [REG_W-1:0] hold_r, hold_nxt;
  logic [REG_W-1:0] hold_inc;
  logic [1:0]       pend_r, pend_nxt;
  logic [1:0]       ev_set;
  logic             fall, rise;

  assign fall     = curr_r & ~ctrl.pin;
  assign rise     = ~curr_r & ctrl.pin;
  assign hold_inc = hold_r + 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    hold_nxt = hold_r;
    ev_set   = 2'b00;
    if (ctrl.sample) begin
      unique case (mode_r)
        MODE_IDLE: begin
          if (fall) begin
            mode_nxt = MODE_HOLD;
            hold_nxt = '0;
          end
        end
        MODE_HOLD: begin
          hold_nxt = hold_inc;
          if (hold_inc >= long_limit) begin
            mode_nxt = MODE_IDLE;
            ev_set   = EV_LONG;
          end
          // release wins the mode even when the limit was reached
          if (rise) begin
            mode_nxt = MODE_RELEASE;
            hold_nxt = '0;
          end
        end
        MODE_RELEASE: begin
          hold_nxt = hold_inc;
          if (hold_inc >= click_delay) begin
            mode_nxt = MODE_IDLE;
            ev_set   = EV_CLICK;
          end
        end
        default: begin
          mode_nxt = mode_r;
        end
      endcase
    end
    pend_nxt = (pend_r | ev_set) & ~ctrl.clr_mask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      prev_r <= 1'b0;
      curr_r <= 1'b0;
      hold_r <= '0;
      pend_r <= 2'b00;
    end else begin
      mode_r <= mode_nxt;
      hold_r <= hold_nxt;
      pend_r <= pend_nxt;
      if (ctrl.sample) begin
        prev_r <= curr_r;
        curr_r <= ctrl.pin;
      end
    end
  end

  assign pending = pend_r;

  // prev_r only feeds the checks below; edges use curr_r against the new pin
  a_clear_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.clr_mask != 2'b00) |=> ((pend_r & $past(ctrl.clr_mask)) == 2'b00))
    else $error("masked events survived a clear");

  a_rise_release: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.sample && mode_r == MODE_HOLD && rise)
      |=> (mode_r == MODE_RELEASE && hold_r == '0 && !prev_r && curr_r))
    else $error("rising edge in hold did not enter release-wait");

  a_no_sample_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && !ctrl.sample) |=> ($stable(mode_r) && $stable(hold_r) && $stable(curr_r)))
    else $error("key machine moved without a sample");

endmodule
`default_nettype wire

[src/key_click_long_press_detector_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// key_click_long_press_detector_core: click / long-press detector
// Prescaled sampling of active-low keys, per-key event latching, and
// tick / check / clear requests answered with one result per item.
// ----------------------------------------------------------------------------
// One item is accepted every clock cycle while in_stall is low; its result passes
// through the input register and then the result register.
// While a result waits on a stalled output, the input register still takes
// one more item, and the input stalls only once both registers are full.
// All key machines update in parallel in the cycle between the two
// registers, so the rate is set by that single stage.
// Configuration registers are 8 bits and take effect on the next item.
module key_click_long_press_detector_core #(
  parameter int unsigned NUM_KEYS = 4
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [1:0]                in_req_type,
  input  wire logic [3:0]                in_pin_levels,
  input  wire logic [1:0]                in_key_index,
  input  wire logic [1:0]                in_event_mask,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic                           out_event_hit,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_index,
  input  wire logic [kcl_pkg::REG_W-1:0] cfg_wdata
);
  import kcl_pkg::*;

  localparam int unsigned PIN_BITS = 4;

  logic [REG_W-1:0] div_r, long_r, click_r;
  logic [REG_W-1:0] tick_r, tick_nxt, tick_inc;
  logic             tick_wrap;

  logic             s1_valid_r;
  logic [1:0]       s1_req_r;
  logic [3:0]       s1_pins_r;
  logic [1:0]       s1_key_r;
  logic [1:0]       s1_mask_r;
  logic             s1_fire;
  logic             in_take;

  logic             out_valid_r;
  logic             out_hit_r;
  logic             hit;

  kcl_key_ctrl_t    key_ctrl [NUM_KEYS];
  logic [1:0]       key_pend [NUM_KEYS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= RST_SAMPLE_DIVIDER;
      long_r  <= RST_LONG_LIMIT;
      click_r <= RST_CLICK_DELAY;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SAMPLE_DIVIDER: div_r   <= cfg_wdata;
        CFG_LONG_LIMIT:     long_r  <= cfg_wdata;
        CFG_CLICK_DELAY:    click_r <= cfg_wdata;
        default:            div_r   <= div_r;
      endcase
    end
  end

  // handshake: the stage advances when the result register is free or drains
  assign s1_fire  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_fire;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_req_r  <= in_req_type;
      s1_pins_r <= in_pin_levels;
      s1_key_r  <= in_key_index;
      s1_mask_r <= in_event_mask;
    end
  end

  // prescaler
  assign tick_inc  = tick_r + 1'b1;
  assign tick_wrap = (s1_req_r == REQ_TICK) && (tick_inc >= div_r);

  always_comb begin
    tick_nxt = tick_r;
    if (s1_fire && s1_req_r == REQ_TICK) begin
      tick_nxt = tick_wrap ? '0 : tick_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= '0;
    end else begin
      tick_r <= tick_nxt;
    end
  end

  // per-key control and check result
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_ctrl[k].sample   = s1_fire && tick_wrap;
      key_ctrl[k].pin      = (k < PIN_BITS) ? s1_pins_r[k % PIN_BITS] : 1'b1;
      key_ctrl[k].clr_mask = 2'b00;
      if (s1_fire && s1_req_r == REQ_CLEAR) begin
        key_ctrl[k].clr_mask = EV_ALL;
      end
      if (s1_req_r == REQ_CHECK && int'(s1_key_r) == k) begin
        if ((key_pend[k] & s1_mask_r) != 2'b00) begin
          hit = 1'b1;
        end
        if (s1_fire) begin
          key_ctrl[k].clr_mask = s1_mask_r;
        end
      end
    end
  end

  for (genvar g = 0; g < NUM_KEYS; g++) begin : g_key
    kcl_key_fsm u_key (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (key_ctrl[g]),
      .long_limit  (long_r),
      .click_delay (click_r),
      .pending     (key_pend[g])
    );
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_hit_r <= hit;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_hit = out_hit_r;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("input stalled with an empty input register");

  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && tick_wrap) |=> (tick_r == '0))
    else $error("prescaler did not restart after a sample");

  a_hit_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_req_r != REQ_CHECK) |=> (out_valid_r && !out_hit_r))
    else $error("hit reported for a non-check item");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("processed item produced no result");

endmodule
`default_nettype wire
